### design/scaled_alpha_blit_defines.svh
// Assertion macros used by the checker file of the scaled alpha blit.
`ifndef SCALED_ALPHA_BLIT_DEFINES_SVH
`define SCALED_ALPHA_BLIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define SAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define SAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sab_pkg.sv
// Types, constants and register codes of the scaled alpha blit.
package sab_pkg;

    localparam int DEF_MAX_CANVAS_WIDTH  = 64;
    localparam int DEF_MAX_CANVAS_HEIGHT = 64;
    localparam int DEF_MAX_REPLICATION   = 4;

    localparam int COORD_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int DEST_W     = 6;
    localparam int POS_W      = 9;
    localparam int SCALE_W    = 7;
    localparam int CSIZE_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    // Replication count before saturation, at most eight.
    localparam int REP_CNT_W  = 4;
    // Layer coordinate times scale, in sixteenths of a pixel.
    localparam int PROD_W     = COORD_W + SCALE_W;
    // Canvas position in sixteenths, two's complement.
    localparam int NUM_W      = PROD_W + 2;
    // Whole-pixel canvas position, two's complement.
    localparam int CRD_W      = NUM_W - 4;

    localparam logic [POS_W-1:0]   RST_POS    = '0;
    localparam logic [SCALE_W-1:0] RST_SCALE  = SCALE_W'(16);
    localparam logic [CSIZE_W-1:0] RST_CANVAS = CSIZE_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_X    = 3'd0,
        CFG_POS_Y    = 3'd1,
        CFG_SCALE_X  = 3'd2,
        CFG_SCALE_Y  = 3'd3,
        CFG_CANVAS_W = 3'd4,
        CFG_CANVAS_H = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [COORD_W-1:0] layer_col;
        logic [COORD_W-1:0] layer_row;
        logic [CHAN_W-1:0]  src_red;
        logic [CHAN_W-1:0]  src_green;
        logic [CHAN_W-1:0]  src_blue;
        logic [CHAN_W-1:0]  src_alpha;
    } t_in_item;

    typedef struct packed {
        logic [DEST_W-1:0] dest_col;
        logic [DEST_W-1:0] dest_row;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              last_write;
    } t_out_item;

endpackage

### design/sab_frame_mem.sv
// Frame store: one write port and one registered read port.
module sab_frame_mem
    import sab_pkg::*;
#(
    parameter int  DEPTH = DEF_MAX_CANVAS_WIDTH * DEF_MAX_CANVAS_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/sab_blend.sv
// Alpha blend datapath: registered weighted sums, then division by 255.
module sab_blend
    import sab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_load,
    input  t_rgb              i_src,
    input  logic [CHAN_W-1:0] i_alpha,
    input  t_rgb              i_old,
    output t_rgb              o_pix
);

    localparam int SUM_W = 2 * CHAN_W;

    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [SUM_W-1:0] n_sum_r, n_sum_g, n_sum_b;
    logic [CHAN_W-1:0] inv_alpha;

    // Exact floor(x / 255) for any x up to 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = (SUM_W + 1)'(x) + (SUM_W + 1)'(1) + (SUM_W + 1)'(x[SUM_W-1:CHAN_W]);
        return t[SUM_W-1:CHAN_W];
    endfunction

    function automatic logic [SUM_W-1:0] wsum(input logic [CHAN_W-1:0] old_c,
                                             input logic [CHAN_W-1:0] src_c,
                                             input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] na);
        return SUM_W'(na) * SUM_W'(old_c) + SUM_W'(a) * SUM_W'(src_c);
    endfunction

    assign inv_alpha = ~i_alpha;

    always_comb begin
        n_sum_r = wsum(i_old.red,   i_src.red,   i_alpha, inv_alpha);
        n_sum_g = wsum(i_old.green, i_src.green, i_alpha, inv_alpha);
        n_sum_b = wsum(i_old.blue,  i_src.blue,  i_alpha, inv_alpha);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
        end
    end

    always_comb begin
        o_pix.red   = div255(r_sum_r);
        o_pix.green = div255(r_sum_g);
        o_pix.blue  = div255(r_sum_b);
    end

endmodule

### design/scaled_alpha_blit.sv
// Top level of the scaled alpha blit: sequencer, configuration and frame store.
//
//   Channel  Dir  Handshake                 Beat contents
//   in       in   i_in_valid / o_in_stall    t_in_item (layer pixel, RGBA)
//   out      out  o_out_valid / i_out_stall  t_out_item (canvas pixel written)
//   cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each input pixel is taken in and prepared, then read, blended and written back
// in the frame store once for every canvas pixel it writes: at most one at scale
// one and up to MAX_REPLICATION**2 for large scales.
// After reset a clearing pass writes black over all MAX_CANVAS_WIDTH *
// MAX_CANVAS_HEIGHT entries (4096 at the defaults) with the input stalled;
// configuration writes are taken at any time. A stalled output holds the
// sequence in its write-back step.
module scaled_alpha_blit
    import sab_pkg::*;
#(
    parameter int MAX_CANVAS_WIDTH  = DEF_MAX_CANVAS_WIDTH,
    parameter int MAX_CANVAS_HEIGHT = DEF_MAX_CANVAS_HEIGHT,
    parameter int MAX_REPLICATION   = DEF_MAX_REPLICATION
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW_W  = $clog2(MAX_CANVAS_WIDTH);
    localparam int CH_W  = $clog2(MAX_CANVAS_HEIGHT);
    localparam int RW    = (MAX_REPLICATION > 1) ? $clog2(MAX_REPLICATION) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_READ,
        S_MUL,
        S_WRITE
    } t_state;

    // Configuration registers
    logic [POS_W-1:0]   r_pos_x, r_pos_y;
    logic [SCALE_W-1:0] r_scale_x, r_scale_y;
    logic [CSIZE_W-1:0] r_canvas_w, r_canvas_h;

    // Sequencer registers
    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    t_rgb               r_src, n_src;
    logic [CHAN_W-1:0]  r_alpha, n_alpha;
    logic [PROD_W-1:0]  r_prod_x, n_prod_x, r_prod_y, n_prod_y;
    logic [RW-1:0]      r_i, n_i, r_j, n_j;
    logic [RW-1:0]      r_last_i, n_last_i, r_first_j, n_first_j, r_last_j, n_last_j;
    logic [AW-1:0]      r_addr, n_addr;
    logic [CW_W-1:0]    r_x, n_x;
    logic [CH_W-1:0]    r_y, n_y;
    logic               r_last, n_last;

    // Per-axis target ranges of the current pixel
    logic [REP_CNT_W-1:0]       reps_x, reps_y;
    logic [CRD_W-1:0]           lim_w, lim_h;
    logic [MAX_REPLICATION-1:0] in_x, in_y;
    logic [RW-1:0]              first_x, last_x, first_y, last_y;
    logic [CRD_W-1:0]           cur_x, cur_y;

    // Frame store and blend connections
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [PIX_W-1:0]   mem_wdata, mem_rdata;
    logic               blend_load;
    t_rgb               blend_pix;

    // ceil(scale / 16), at least one and at most MAX_REPLICATION.
    function automatic logic [REP_CNT_W-1:0] reps_of(input logic [SCALE_W-1:0] s);
        logic [REP_CNT_W-1:0] raw;
        raw = REP_CNT_W'(((SCALE_W + 1)'(s) + (SCALE_W + 1)'(15)) >> 4);
        if (raw == '0) begin
            raw = REP_CNT_W'(1);
        end else if (raw > REP_CNT_W'(MAX_REPLICATION)) begin
            raw = REP_CNT_W'(MAX_REPLICATION);
        end
        return raw;
    endfunction

    // Whole-pixel position trunc(pos + off + prod / 16), rounded toward zero.
    function automatic logic [CRD_W-1:0] place(input logic [POS_W-1:0]  pos,
                                              input logic [RW-1:0]     off,
                                              input logic [PROD_W-1:0] prod);
        logic [NUM_W-1:0] num;
        logic [CRD_W-1:0] q;
        num = (({{(NUM_W - POS_W){pos[POS_W-1]}}, pos} + NUM_W'(off)) << 4)
              + NUM_W'(prod);
        q = num[NUM_W-1:4];
        if (num[NUM_W-1] && (num[3:0] != 4'd0)) begin
            q = q + CRD_W'(1);
        end
        return q;
    endfunction

    function automatic logic is_inside(input logic [CRD_W-1:0] q,
                                       input logic [CRD_W-1:0] lim);
        return !q[CRD_W-1] && (q < lim);
    endfunction

    assign reps_x = reps_of(r_scale_x);
    assign reps_y = reps_of(r_scale_y);
    assign lim_w  = (CRD_W'(r_canvas_w) > CRD_W'(MAX_CANVAS_WIDTH)) ?
                    CRD_W'(MAX_CANVAS_WIDTH) : CRD_W'(r_canvas_w);
    assign lim_h  = (CRD_W'(r_canvas_h) > CRD_W'(MAX_CANVAS_HEIGHT)) ?
                    CRD_W'(MAX_CANVAS_HEIGHT) : CRD_W'(r_canvas_h);

    // Positions grow with the offset, so the targets inside form one range per axis.
    always_comb begin
        first_x = '0;
        last_x  = '0;
        first_y = '0;
        last_y  = '0;
        for (int k = 0; k < MAX_REPLICATION; k++) begin
            in_x[k] = (REP_CNT_W'(k) < reps_x) &&
                      is_inside(place(r_pos_x, RW'(k), r_prod_x), lim_w);
            in_y[k] = (REP_CNT_W'(k) < reps_y) &&
                      is_inside(place(r_pos_y, RW'(k), r_prod_y), lim_h);
        end
        for (int k = 0; k < MAX_REPLICATION; k++) begin
            if (in_x[k]) begin
                last_x = RW'(k);
            end
            if (in_y[k]) begin
                last_y = RW'(k);
            end
        end
        for (int k = MAX_REPLICATION - 1; k >= 0; k--) begin
            if (in_x[k]) begin
                first_x = RW'(k);
            end
            if (in_y[k]) begin
                first_y = RW'(k);
            end
        end
    end

    assign cur_x = place(r_pos_x, r_i, r_prod_x);
    assign cur_y = place(r_pos_y, r_j, r_prod_y);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_src       = r_src;
        n_alpha     = r_alpha;
        n_prod_x    = r_prod_x;
        n_prod_y    = r_prod_y;
        n_i         = r_i;
        n_j         = r_j;
        n_last_i    = r_last_i;
        n_first_j   = r_first_j;
        n_last_j    = r_last_j;
        n_addr      = r_addr;
        n_x         = r_x;
        n_y         = r_y;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = blend_pix;
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_y) * AW'(MAX_CANVAS_WIDTH) + AW'(r_x);
        blend_load  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_src.red   = i_in_data.src_red;
                    n_src.green = i_in_data.src_green;
                    n_src.blue  = i_in_data.src_blue;
                    n_alpha     = i_in_data.src_alpha;
                    n_prod_x    = PROD_W'(i_in_data.layer_col) * PROD_W'(r_scale_x);
                    n_prod_y    = PROD_W'(i_in_data.layer_row) * PROD_W'(r_scale_y);
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                n_i       = first_x;
                n_j       = first_y;
                n_last_i  = last_x;
                n_first_j = first_y;
                n_last_j  = last_y;
                n_state   = ((|in_x) && (|in_y)) ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_x       = cur_x[CW_W-1:0];
                n_y       = cur_y[CH_W-1:0];
                mem_re    = 1'b1;
                mem_raddr = AW'(n_y) * AW'(MAX_CANVAS_WIDTH) + AW'(n_x);
                n_addr    = mem_raddr;
                n_last    = (r_i == r_last_i) && (r_j == r_last_j);
                n_state   = S_MUL;
            end
            S_MUL: begin
                blend_load = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                // Write back and hand over the beat together, so the store and
                // the output never disagree.
                if (!r_out_valid || !i_out_stall) begin
                    mem_we             = 1'b1;
                    n_out_valid        = 1'b1;
                    n_out.dest_col     = DEST_W'(r_x);
                    n_out.dest_row     = DEST_W'(r_y);
                    n_out.out_red      = blend_pix.red;
                    n_out.out_green    = blend_pix.green;
                    n_out.out_blue     = blend_pix.blue;
                    n_out.last_write   = r_last;
                    if (r_j == r_last_j) begin
                        n_j = r_first_j;
                        n_i = r_i + RW'(1);
                    end else begin
                        n_j = r_j + RW'(1);
                    end
                    n_state = r_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_out     <= n_out;
        r_src     <= n_src;
        r_alpha   <= n_alpha;
        r_prod_x  <= n_prod_x;
        r_prod_y  <= n_prod_y;
        r_i       <= n_i;
        r_j       <= n_j;
        r_last_i  <= n_last_i;
        r_first_j <= n_first_j;
        r_last_j  <= n_last_j;
        r_addr    <= n_addr;
        r_x       <= n_x;
        r_y       <= n_y;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= RST_POS;
            r_pos_y    <= RST_POS;
            r_scale_x  <= RST_SCALE;
            r_scale_y  <= RST_SCALE;
            r_canvas_w <= RST_CANVAS;
            r_canvas_h <= RST_CANVAS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POS_X:    r_pos_x    <= i_cfg_data;
                CFG_POS_Y:    r_pos_y    <= i_cfg_data;
                CFG_SCALE_X:  r_scale_x  <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:  r_scale_y  <= i_cfg_data[SCALE_W-1:0];
                CFG_CANVAS_W: r_canvas_w <= i_cfg_data[CSIZE_W-1:0];
                CFG_CANVAS_H: r_canvas_h <= i_cfg_data[CSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    sab_frame_mem #(
        .DEPTH (DEPTH)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sab_blend u_blend (
        .i_clk   (i_clk),
        .i_load  (blend_load),
        .i_src   (r_src),
        .i_alpha (r_alpha),
        .i_old   (t_rgb'(mem_rdata)),
        .o_pix   (blend_pix)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

### design/sab_checker.sv
// Port-level assertions of the scaled alpha blit and their bind.
`include "scaled_alpha_blit_defines.svh"

module sab_checker
    import sab_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    `SAB_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall,
        i_out_valid && $stable(i_out_data), "stalled output beat changed")

    `SAB_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !i_in_stall,
        i_in_stall, "input taken again before the previous pixel was done")

    `SAB_ASSERT_NOW(a_busy_until_last, i_out_valid && !i_out_data.last_write,
        i_in_stall, "input taken while a pixel still has writes to go")

    `SAB_ASSERT_NOW(a_reset_clear, $rose(i_rst_n),
        i_in_stall && !i_out_valid, "input open or output valid right after reset")

endmodule

bind scaled_alpha_blit sab_checker u_sab_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
